/* rtl/msq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package msq_pkg;

   // Queue geometry.
   localparam int SLOTS      = 16;
   localparam int SLOT_BYTES = 2048;

   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int OFF_W      = $clog2(SLOT_BYTES);
   localparam int LEN_W      = $clog2(SLOT_BYTES + 1);
   localparam int BYTE_DEPTH = SLOTS * SLOT_BYTES;
   localparam int ADDR_W     = $clog2(BYTE_DEPTH);
   localparam int MLEN_W     = 12;

   // Commands.
   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_TRUNC = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        data_out;
      logic              out_last;
      logic [MLEN_W-1:0] msg_length;
   } rsp_type;

   // Write side of the byte store.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } byte_wr_type;

   // Update of the slot length table.
   typedef struct packed {
      logic              clear_all;
      logic              set;
      logic              free;
      logic [SLOT_W-1:0] addr;
      logic [LEN_W-1:0]  len;
   } len_wr_type;

   // Registered read-out of the slot length table.
   typedef struct packed {
      logic             head_full;
      logic [LEN_W-1:0] head_len;
      logic             tail_full;
   } len_rd_type;

   function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [OFF_W-1:0]  off);
      byte_addr = ADDR_W'(slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off);
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
      next_slot = (slot == SLOT_W'(SLOTS - 1)) ? '0 : slot + 1'b1;
   endfunction

endpackage

`default_nettype wire

/* rtl/msq_byte_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module msq_byte_ram (
   input  wire logic                        clock,
   input  wire msq_pkg::byte_wr_type        wr,
   input  wire logic                        re,
   input  wire logic [msq_pkg::ADDR_W-1:0]  raddr,
   output logic [7:0]                       rdata
);
   import msq_pkg::*;

   // Message bytes of all slots, one slot after another.
   logic [7:0] mem [BYTE_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/msq_len_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module msq_len_ram (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire msq_pkg::len_wr_type         wr,
   input  wire logic                        re,
   input  wire logic [msq_pkg::SLOT_W-1:0]  head_addr,
   input  wire logic [msq_pkg::SLOT_W-1:0]  tail_addr,
   output msq_pkg::len_rd_type              rd
);
   import msq_pkg::*;

   // Lengths are only meaningful where the full bit is set; the full bits
   // alone are cleared by reset and by a queue clear.
   logic [LEN_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0] full_ff;
   len_rd_type       rd_ff;

   always_ff @(posedge clock) begin
      if (wr.set) begin
         mem[wr.addr] <= wr.len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || wr.clear_all) begin
         full_ff <= '0;
      end else if (wr.set) begin
         full_ff[wr.addr] <= 1'b1;
      end else if (wr.free) begin
         full_ff[wr.addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_ff.head_full <= full_ff[head_addr];
         rd_ff.head_len  <= mem[head_addr];
         rd_ff.tail_full <= full_ff[tail_addr];
      end
   end

   assign rd = rd_ff;

endmodule

`default_nettype wire

/* rtl/message_slot_queue_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Message slot queue: a ring of SLOTS slots of SLOT_BYTES bytes each, fed and
// drained one byte per command. A command is taken when start is high and busy
// is low; every command gives exactly one result, shown on rsp_item for a single
// cycle with rsp_valid high and registered at the end of its execute state. The
// receiver cannot hold results off, so it must take each result transfer in the
// cycle it appears. Taking a command reads the byte store and the slot length
// table (both synchronous memories with registered read data); the execute
// state then decides, writes back and registers the result. busy is high in
// the execute state, so a new command may be offered in the same cycle as the
// previous result. Pushing into an occupied tail slot drops the whole message
// with status full; bytes beyond the slot size are dropped with status
// truncated. Popping a free head slot reports empty. A clear empties the queue
// at once; the byte store keeps its contents and needs no clearing pass.

module message_slot_queue_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire msq_pkg::req_type req_item,
   output logic                  rsp_valid,
   output msq_pkg::rsp_type      rsp_item
);
   import msq_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic              state_ff, state_in;
   req_type           req_ff;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [LEN_W-1:0]  wr_off_ff, wr_off_in;
   logic [OFF_W-1:0]  rd_off_ff, rd_off_in;
   logic              drop_ff, drop_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic [7:0]        byte_rdata;
   byte_wr_type       byte_wr;
   len_wr_type        len_wr;
   len_rd_type        len_rd;

   // Working values of the execute cycle.
   logic              drop_now;
   logic              ovf_now;
   logic [LEN_W-1:0]  wr_off_inc;
   logic [LEN_W-1:0]  rd_off_inc;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff == S_EXEC);

   // Reads are issued on every accepted command; only a pop uses the byte.
   msq_byte_ram u_byte_ram (
      .clock (clock),
      .wr    (byte_wr),
      .re    (accept),
      .raddr (byte_addr(head_ff, rd_off_ff)),
      .rdata (byte_rdata)
   );

   msq_len_ram u_len_ram (
      .clock     (clock),
      .reset     (reset),
      .wr        (len_wr),
      .re        (accept),
      .head_addr (head_ff),
      .tail_addr (tail_ff),
      .rd        (len_rd)
   );

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      wr_off_in  = wr_off_ff;
      rd_off_in  = rd_off_ff;
      drop_in    = drop_ff;
      ovf_in     = ovf_ff;
      rsp_in     = '0;
      byte_wr    = '0;
      len_wr     = '0;
      drop_now   = 1'b0;
      ovf_now    = ovf_ff;
      wr_off_inc = wr_off_ff + 1'b1;
      rd_off_inc = LEN_W'(rd_off_ff) + 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            unique case (req_ff.cmd)
               CMD_PUSH: begin
                  // A message that starts on an occupied tail is dropped whole.
                  drop_now = drop_ff ||
                             ((wr_off_ff == '0) && len_rd.tail_full);
                  if (drop_now) begin
                     rsp_in.status = ST_FULL;
                     drop_in       = !req_ff.last_byte;
                  end else begin
                     if (wr_off_ff < LEN_W'(SLOT_BYTES)) begin
                        byte_wr.we   = 1'b1;
                        byte_wr.addr = byte_addr(tail_ff, wr_off_ff[OFF_W-1:0]);
                        byte_wr.data = req_ff.data_byte;
                        wr_off_in    = wr_off_inc;
                     end else begin
                        ovf_now = 1'b1;
                     end
                     ovf_in        = ovf_now;
                     rsp_in.status = ovf_now ? ST_TRUNC : ST_DONE;
                     if (req_ff.last_byte) begin
                        len_wr.set        = 1'b1;
                        len_wr.addr       = tail_ff;
                        len_wr.len        = wr_off_in;
                        rsp_in.msg_length = MLEN_W'(wr_off_in);
                        tail_in           = next_slot(tail_ff);
                        wr_off_in         = '0;
                        ovf_in            = 1'b0;
                     end
                  end
               end
               CMD_POP: begin
                  if (!len_rd.head_full) begin
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     rsp_in.data_out   = byte_rdata;
                     rsp_in.msg_length = MLEN_W'(len_rd.head_len);
                     if (rd_off_inc >= len_rd.head_len) begin
                        rsp_in.out_last = 1'b1;
                        len_wr.free     = 1'b1;
                        len_wr.addr     = head_ff;
                        head_in         = next_slot(head_ff);
                        rd_off_in       = '0;
                     end else begin
                        rd_off_in = rd_off_inc[OFF_W-1:0];
                     end
                  end
               end
               CMD_CLEAR: begin
                  len_wr.clear_all = 1'b1;
                  head_in          = '0;
                  tail_in          = '0;
                  wr_off_in        = '0;
                  rd_off_in        = '0;
                  drop_in          = 1'b0;
                  ovf_in           = 1'b0;
               end
               default: begin
                  // Unused command: plain done result, no state change.
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         wr_off_ff    <= '0;
         rd_off_ff    <= '0;
         drop_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wr_off_ff    <= wr_off_in;
         rd_off_ff    <= rd_off_in;
         drop_ff      <= drop_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= (state_ff == S_EXEC);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (state_ff == S_EXEC) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A taken command is executed in exactly the following cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command not executed");

   // Every execute cycle is followed by exactly one result transfer.
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("execute cycle without a result");

   // A result is only ever shown after an execute cycle.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a command");

   // The byte that ends a message is a successful pop of a non-empty slot.
   a_last_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.out_last) |->
         ((rsp_item.status == ST_DONE) && (rsp_item.msg_length != '0)))
      else $error("end of message on a failed or empty pop");

endmodule

`default_nettype wire

/* verif/message_slot_queue_core_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the message slot queue core.
//
// The bench drives command transfers on the req_ side with start/busy, and
// catches every result transfer on the rsp_ side in the single cycle in which
// rsp_valid is high. The receiver cannot hold results off, so only the sender
// idles. Inputs change on the falling clock edge and everything is sampled on
// the rising edge, so no check depends on the order of events within a step.
//
// A behavioural copy of the queue is kept in the bench: a byte store, a table
// of slot lengths, head and tail slot numbers, the fill and drain offsets and
// the two flags of a message being pushed. It is stepped once for every
// accepted command, and the result it gives is queued. Each result transfer is
// compared field by field with the oldest queued result.
//
// The stimulus runs in several parts:
//  - a short directed table covering reset, the unused command, the extreme
//    byte values, popping an empty queue, popping while a push is still in
//    progress, and clearing with and without a message in progress;
//  - a fill pass, which occupies every slot and then pushes into a full queue,
//    freeing a slot half way through a dropped message;
//  - a long pass, which pushes one message a byte over the slot size, so that
//    the largest length and the truncated status are both seen, pops its first
//    bytes and then clears the queue with the rest of it unread;
//  - random traffic, made mostly of whole messages and pop bursts, with some
//    clears, unused commands and broken messages in between.
module message_slot_queue_core_tb;

   import msq_pkg::*;

   // The encoding that the block treats as no operation.
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 360;
   localparam int MAX_REPORTS  = 40;

   // A row of the directed table. Where pin_result is set, the expected
   // result is taken from the row rather than from the queue model.
   typedef struct packed {
      req_type cmd_item;
      logic    pin_result;
      rsp_type pinned;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   message_slot_queue_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Model of the queue. Offsets and slot numbers are kept as plain integers.
   logic [7:0]  model_bytes [BYTE_DEPTH];
   int unsigned model_len   [SLOTS];
   int unsigned model_head;
   int unsigned model_tail;
   int unsigned fill_count;
   int unsigned drain_count;
   logic        discarding;
   logic        overrun;

   rsp_type     expected_results [$];
   dir_row_type directed_rows [$];

   // Set by the driver together with req_item, read by the monitor.
   logic        row_pinned;
   rsp_type     row_result;

   rsp_type     fresh_result;
   rsp_type     oldest_result;

   int          sender_idle_pct;
   int          issued_items;
   int          mismatches;
   int          cycle_count;
   int          done_seen;
   int          full_seen;
   int          empty_seen;
   int          trunc_seen;
   int          longest_seen;
   logic        fill_bias;

   function automatic void clear_model();
      for (int s = 0; s < SLOTS; s++) begin
         model_len[s] = 0;
      end
      model_head  = 0;
      model_tail  = 0;
      fill_count  = 0;
      drain_count = 0;
      discarding  = 1'b0;
      overrun     = 1'b0;
   endfunction

   // Steps the model by one command and returns the result it must produce.
   function automatic rsp_type next_queue_result(input req_type r);
      rsp_type     res;
      int unsigned cur_len;
      res        = '0;
      res.status = ST_DONE;
      case (r.cmd)
         CMD_PUSH: begin
            // The first byte of a message decides whether the tail slot is
            // free; if not, the message is thrown away up to its last byte.
            if (fill_count == 0 && !discarding && model_len[model_tail] != 0) begin
               discarding = 1'b1;
            end
            if (discarding) begin
               res.status = ST_FULL;
               if (r.last_byte) begin
                  discarding = 1'b0;
               end
            end else begin
               if (fill_count < SLOT_BYTES) begin
                  model_bytes[model_tail * SLOT_BYTES + fill_count] = r.data_byte;
                  fill_count++;
               end else begin
                  overrun = 1'b1;
               end
               if (overrun) begin
                  res.status = ST_TRUNC;
               end
               if (r.last_byte) begin
                  model_len[model_tail] = fill_count;
                  res.msg_length        = MLEN_W'(fill_count);
                  model_tail            = (model_tail + 1) % SLOTS;
                  fill_count            = 0;
                  overrun               = 1'b0;
               end
            end
         end
         CMD_POP: begin
            cur_len = model_len[model_head];
            if (cur_len == 0) begin
               res.status = ST_EMPTY;
            end else begin
               if (cur_len > SLOT_BYTES) begin
                  cur_len = SLOT_BYTES;
               end
               if (drain_count >= cur_len) begin
                  drain_count = cur_len - 1;
               end
               res.data_out   = model_bytes[model_head * SLOT_BYTES + drain_count];
               res.msg_length = MLEN_W'(cur_len);
               drain_count++;
               if (drain_count >= cur_len) begin
                  res.out_last          = 1'b1;
                  model_len[model_head] = 0;
                  model_head            = (model_head + 1) % SLOTS;
                  drain_count           = 0;
               end
            end
         end
         CMD_CLEAR: begin
            clear_model();
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic void note_mismatch(input string field, input logic [11:0] want,
                                         input logic [11:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, field, want, got);
      end
   endfunction

   function automatic dir_row_type mk_row(input logic [1:0] cmd, input logic [7:0] b,
                                          input logic l, input logic pin,
                                          input logic [1:0] st, input logic [7:0] dout,
                                          input logic olast, input int mlen);
      dir_row_type row;
      row.cmd_item.cmd       = cmd;
      row.cmd_item.data_byte = b;
      row.cmd_item.last_byte = l;
      row.pin_result         = pin;
      row.pinned.status      = st;
      row.pinned.data_out    = dout;
      row.pinned.out_last    = olast;
      row.pinned.msg_length  = MLEN_W'(mlen);
      return row;
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Monitor. A result transfer is checked before the command accepted at the
   // same edge is stepped through the model; the result always belongs to an
   // older command.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t ns: result transfer with nothing expected, got %0h",
                           $time, rsp_item);
               end
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_item.status !== oldest_result.status) begin
                  note_mismatch("status", 12'(oldest_result.status), 12'(rsp_item.status));
               end
               if (rsp_item.data_out !== oldest_result.data_out) begin
                  note_mismatch("data_out", 12'(oldest_result.data_out),
                                12'(rsp_item.data_out));
               end
               if (rsp_item.out_last !== oldest_result.out_last) begin
                  note_mismatch("out_last", 12'(oldest_result.out_last),
                                12'(rsp_item.out_last));
               end
               if (rsp_item.msg_length !== oldest_result.msg_length) begin
                  note_mismatch("msg_length", oldest_result.msg_length,
                                rsp_item.msg_length);
               end
               case (oldest_result.status)
                  ST_DONE:  done_seen++;
                  ST_FULL:  full_seen++;
                  ST_EMPTY: empty_seen++;
                  default:  trunc_seen++;
               endcase
               if (int'(oldest_result.msg_length) > longest_seen) begin
                  longest_seen = int'(oldest_result.msg_length);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            fresh_result = next_queue_result(req_item);
            if (row_pinned) begin
               fresh_result = row_result;
            end
            expected_results.push_back(fresh_result);
         end
      end
   end

   // Watchdog: a hang or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: run stopped after %0d cycles, %0d results still expected",
                  $time, cycle_count, expected_results.size());
         $display("message_slot_queue_core_tb: FAIL");
         $finish;
      end
   end

   // Offers one command transfer, after a random number of idle cycles, and
   // returns on the falling edge after it has been taken. start stays high
   // across back-to-back transfers.
   task automatic send_item(input req_type it, input logic pin, input rsp_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_item   <= it;
      start      <= 1'b1;
      row_pinned = pin;
      row_result = want;
      @(posedge clock);
      while (busy !== 1'b0) begin
         @(posedge clock);
      end
      if (it.cmd != CMD_SPARE) begin
         issued_items++;
      end
      @(negedge clock);
   endtask

   task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] b, input logic l);
      req_type it;
      it.cmd       = cmd;
      it.data_byte = b;
      it.last_byte = l;
      send_item(it, 1'b0, '0);
   endtask

   task automatic push_message(input int len);
      for (int i = 1; i <= len; i++) begin
         send_cmd(CMD_PUSH, 8'($urandom), i == len);
      end
   endtask

   task automatic pop_bytes(input int n);
      for (int i = 0; i < n; i++) begin
         send_cmd(CMD_POP, 8'($urandom), 1'($urandom));
      end
   endtask

   // The sender holds off until every outstanding result has arrived.
   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // One step of random traffic. Most steps are whole messages or bursts of
   // pops; the bias between the two swings back and forth so that the queue
   // is driven both into the full state and down to empty.
   task automatic random_action();
      int pick;
      int len;
      pick = $urandom_range(99);
      if (pick < 2) begin
         send_cmd(CMD_CLEAR, 8'($urandom), 1'($urandom));
      end else if (pick < 4) begin
         send_cmd(CMD_SPARE, 8'($urandom), 1'($urandom));
      end else if (pick < 8) begin
         // A broken message: pops or a clear land while it is half pushed.
         push_message(0);
         for (int i = $urandom_range(1, 3); i > 0; i--) begin
            send_cmd(CMD_PUSH, 8'($urandom), 1'b0);
         end
         if ($urandom_range(3) == 0) begin
            send_cmd(CMD_CLEAR, 8'($urandom), 1'($urandom));
         end else begin
            pop_bytes($urandom_range(1, 3));
            send_cmd(CMD_PUSH, 8'($urandom), 1'b1);
         end
      end else if (pick < (fill_bias ? 65 : 35)) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
         push_message(len);
      end else begin
         pop_bytes($urandom_range(1, 10));
      end
   endtask

   task automatic random_phase(input int idle_pct, input int items);
      int stop_at;
      int steps;
      sender_idle_pct = idle_pct;
      stop_at         = issued_items + items;
      steps           = 0;
      while (issued_items < stop_at) begin
         random_action();
         steps++;
         if (steps % 40 == 0) begin
            fill_bias = ~fill_bias;
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_item        = '0;
      row_pinned      = 1'b0;
      row_result      = '0;
      sender_idle_pct = 34;
      issued_items    = 0;
      mismatches      = 0;
      cycle_count     = 0;
      done_seen       = 0;
      full_seen       = 0;
      empty_seen      = 0;
      trunc_seen      = 0;
      longest_seen    = 0;
      fill_bias       = 1'b1;
      for (int i = 0; i < BYTE_DEPTH; i++) begin
         model_bytes[i] = '0;
      end
      clear_model();

      // Directed table. Pinned rows carry a result that can be read straight
      // off the behaviour; the others are left to the model.
      directed_rows.push_back(mk_row(CMD_POP,   8'h00, 1'b0, 1'b1, ST_EMPTY, 8'h00, 1'b0, 0));
      directed_rows.push_back(mk_row(CMD_SPARE, 8'hFF, 1'b1, 1'b1, ST_DONE,  8'h00, 1'b0, 0));
      directed_rows.push_back(mk_row(CMD_PUSH,  8'h00, 1'b0, 1'b1, ST_DONE,  8'h00, 1'b0, 0));
      directed_rows.push_back(mk_row(CMD_PUSH,  8'hFF, 1'b1, 1'b1, ST_DONE,  8'h00, 1'b0, 2));
      directed_rows.push_back(mk_row(CMD_POP,   8'hFF, 1'b1, 1'b1, ST_DONE,  8'h00, 1'b0, 2));
      directed_rows.push_back(mk_row(CMD_POP,   8'h00, 1'b0, 1'b1, ST_DONE,  8'hFF, 1'b1, 2));
      directed_rows.push_back(mk_row(CMD_POP,   8'h00, 1'b0, 1'b1, ST_EMPTY, 8'h00, 1'b0, 0));
      // Pop while a message is half pushed: its slot still reads as free.
      directed_rows.push_back(mk_row(CMD_PUSH,  8'hA5, 1'b0, 1'b0, ST_DONE,  8'h00, 1'b0, 0));
      directed_rows.push_back(mk_row(CMD_POP,   8'h00, 1'b0, 1'b1, ST_EMPTY, 8'h00, 1'b0, 0));
      directed_rows.push_back(mk_row(CMD_PUSH,  8'h5A, 1'b1, 1'b0, ST_DONE,  8'h00, 1'b0, 0));
      directed_rows.push_back(mk_row(CMD_PUSH,  8'h3C, 1'b1, 1'b0, ST_DONE,  8'h00, 1'b0, 0));
      directed_rows.push_back(mk_row(CMD_POP,   8'h00, 1'b0, 1'b0, ST_DONE,  8'h00, 1'b0, 0));
      directed_rows.push_back(mk_row(CMD_CLEAR, 8'h00, 1'b0, 1'b1, ST_DONE,  8'h00, 1'b0, 0));
      directed_rows.push_back(mk_row(CMD_POP,   8'h00, 1'b0, 1'b1, ST_EMPTY, 8'h00, 1'b0, 0));
      // Clear with a message in progress abandons that message.
      directed_rows.push_back(mk_row(CMD_PUSH,  8'h81, 1'b0, 1'b0, ST_DONE,  8'h00, 1'b0, 0));
      directed_rows.push_back(mk_row(CMD_CLEAR, 8'hFF, 1'b1, 1'b1, ST_DONE,  8'h00, 1'b0, 0));
      directed_rows.push_back(mk_row(CMD_PUSH,  8'h7E, 1'b1, 1'b1, ST_DONE,  8'h00, 1'b0, 1));
      directed_rows.push_back(mk_row(CMD_POP,   8'h00, 1'b0, 1'b1, ST_DONE,  8'h7E, 1'b1, 1));
      directed_rows.push_back(mk_row(CMD_POP,   8'h00, 1'b0, 1'b1, ST_EMPTY, 8'h00, 1'b0, 0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].cmd_item, directed_rows[i].pin_result,
                   directed_rows[i].pinned);
      end
      wait_drained();

      // Fill pass: every slot taken, then a message pushed into a full queue.
      // A slot is freed part way through the dropped message, which must
      // still be dropped to its last byte.
      send_cmd(CMD_CLEAR, 8'h00, 1'b0);
      for (int m = 0; m < SLOTS; m++) begin
         push_message(2);
      end
      send_cmd(CMD_PUSH, 8'($urandom), 1'b0);
      pop_bytes(2);
      send_cmd(CMD_PUSH, 8'($urandom), 1'b0);
      send_cmd(CMD_PUSH, 8'($urandom), 1'b1);
      push_message(3);
      pop_bytes(2 * SLOTS + 4);
      wait_drained();

      // Long pass: a message one byte over the slot size, which is cut at the
      // slot size and reported truncated. Its first bytes are popped, then the
      // queue is cleared with the rest of the message still unread.
      sender_idle_pct = 10;
      send_cmd(CMD_CLEAR, 8'h00, 1'b0);
      push_message(SLOT_BYTES + 1);
      pop_bytes(2);
      send_cmd(CMD_CLEAR, 8'h00, 1'b0);
      pop_bytes(1);
      wait_drained();

      // Random traffic in three stretches of sender idling.
      random_phase(34, RANDOM_ITEMS / 3);
      wait_drained();
      random_phase(47, RANDOM_ITEMS / 3);
      wait_drained();
      random_phase(0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

      // Let the last results through, then keep watching for any stray
      // transfer.
      wait_drained();
      repeat (6) @(negedge clock);
      if (expected_results.size() != 0) begin
         mismatches++;
      end

      $display("Run covered %0d commands in %0d cycles, longest message %0d bytes.",
               issued_items, cycle_count, longest_seen);
      $display("Results seen: %0d done, %0d full, %0d empty, %0d truncated; %0d mismatches.",
               done_seen, full_seen, empty_seen, trunc_seen, mismatches);
      if (mismatches == 0) begin
         $display("message_slot_queue_core_tb: PASS");
      end else begin
         $display("message_slot_queue_core_tb: FAIL");
      end
      $finish;
   end

endmodule
